// ----- hw/rtl/ftpd_pkg.sv -----
// Shared types and constants for the file transfer packet deframer.
package ftpd_pkg;

    localparam int CONTROL_BYTES = 1024;
    localparam int CTRL_ADDR_W = $clog2(CONTROL_BYTES);
    // One more bit so the index can hold the full store depth.
    localparam int CTRL_IDX_W = CTRL_ADDR_W + 1;

    localparam logic [7:0] PKT_DATA  = 8'h01;
    localparam logic [7:0] PKT_START = 8'h02;
    localparam logic [7:0] PKT_END   = 8'h03;
    localparam logic [7:0] TLV_SIZE  = 8'h00;
    localparam logic [7:0] TLV_NAME  = 8'h01;

    localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_MATCH    = 3'd2;
    localparam logic [2:0] KIND_MISMATCH = 3'd3;
    localparam logic [2:0] KIND_NAME     = 3'd4;

    typedef enum logic [3:0] {
        ST_WAIT_START,
        ST_S_TYPE,
        ST_S_LEN,
        ST_S_VAL,
        ST_START_PEND,
        ST_D_WAIT,
        ST_D_SEQ,
        ST_D_HI,
        ST_D_LO,
        ST_D_PAY,
        ST_E_WAIT,
        ST_E_TYPE,
        ST_E_LEN,
        ST_E_VAL
    } t_state;

    // Work handed from the parse stage to the compare and output stage.
    typedef struct packed {
        logic        emit;
        logic        verdict;
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [7:0]  seq;
        logic        last;
        logic [31:0] size;
        logic        cmp;
        logic        oob;
        logic [7:0]  cmp_byte;
        logic        clr_mm;
        logic        len_fail;
    } t_stage;

endpackage

// ----- hw/rtl/file_transfer_packet_deframer.sv -----
// File transfer packet deframer: parse stage, control field store and verdict stage.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------------
//   in      | i_valid / o_ready   | i_rx_byte
//   out     | o_valid / i_ready   | o_kind, o_data_byte, o_sequence_res,
//           |                     | o_packet_last, o_decoded_size
//
// One byte is taken per cycle while o_ready is high; a result passes through
// the r_s1 stage register and the output register. The end packet's bytes are
// checked against the control store in the second stage, using the store's
// registered read port, so the verdict is settled there. i_rst_n is synchronous
// and clears the control state; the store itself is not cleared. A stalled
// output holds the second stage, which in turn holds o_ready low.
module file_transfer_packet_deframer
    import ftpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_sequence_res,
    output logic        o_packet_last,
    output logic [31:0] o_decoded_size
);

    t_state                r_state, n_state;
    logic [1:0]            r_fields, n_fields;
    logic [15:0]           r_remain, n_remain;
    logic                  r_ftype, n_ftype;
    logic [CTRL_IDX_W-1:0] r_idx, n_idx;
    logic [31:0]           r_size, n_size;
    logic [31:0]           r_bytes, n_bytes;
    logic [7:0]            r_seq, n_seq;
    logic                  r_mismatch;

    t_stage                r_s1, n_s1;
    logic                  r_s1_valid;

    logic [7:0]            r_ctrl_mem [CONTROL_BYTES];
    logic [7:0]            r_rdata;
    logic                  w_we;
    logic                  w_re;

    logic                  r_o_valid;
    logic [2:0]            r_o_kind;
    logic [7:0]            r_o_data;
    logic [7:0]            r_o_seq;
    logic                  r_o_last;
    logic [31:0]           r_o_size;

    logic                  w_accept;
    logic                  w_s1_adv;
    logic                  w_cmp_fail;
    logic                  w_mm_eff;
    logic [7:0]            w_b;
    logic [1:0]            w_fields_inc;
    logic                  w_fields_done;
    logic                  w_idx_ok;
    logic                  w_tlv_type;
    logic [15:0]           w_val_remain;
    logic [15:0]           w_len_remain;
    logic [15:0]           w_pay_remain;
    logic [31:0]           w_bytes_inc;
    logic [7:0]            w_end_remain;

    assign w_b           = i_rx_byte;
    assign w_fields_inc  = r_fields + 2'd1;
    assign w_fields_done = (w_fields_inc >= 2'd2);
    assign w_idx_ok      = (r_idx < CTRL_IDX_W'(CONTROL_BYTES));
    assign w_tlv_type    = (w_b[7:1] == 7'd0);
    assign w_val_remain  = r_remain + 16'h00FF;
    assign w_len_remain  = {r_remain[15:8], w_b};
    assign w_pay_remain  = r_remain - 16'd1;
    assign w_bytes_inc   = (r_bytes == 32'hFFFF_FFFF) ? r_bytes : r_bytes + 32'd1;
    assign w_end_remain  = r_remain[7:0] - 8'd1;

    assign w_s1_adv = r_s1_valid && (!r_s1.emit || !r_o_valid || i_ready);
    assign o_ready  = !r_s1_valid || w_s1_adv;
    assign w_accept = i_valid && o_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_WAIT_START: begin
                if (w_b == PKT_START) n_state = ST_S_TYPE;
            end
            ST_S_TYPE: begin
                if (w_tlv_type) n_state = ST_S_LEN;
            end
            ST_E_TYPE: begin
                if (w_tlv_type) n_state = ST_E_LEN;
            end
            ST_S_LEN: begin
                if (w_b != 8'd0) begin
                    n_state = ST_S_VAL;
                end else if (w_fields_done) begin
                    n_state = ST_D_WAIT;
                end else begin
                    n_state = ST_S_TYPE;
                end
            end
            ST_S_VAL: begin
                if (w_val_remain[7:0] == 8'd0) begin
                    if (!w_fields_done) begin
                        n_state = ST_S_TYPE;
                    end else if (r_ftype) begin
                        n_state = ST_START_PEND;
                    end else begin
                        n_state = ST_D_WAIT;
                    end
                end
            end
            ST_START_PEND: begin
                n_state = (w_b == PKT_DATA) ? ST_D_SEQ : ST_D_WAIT;
            end
            ST_D_WAIT: begin
                if (w_b == PKT_DATA) n_state = ST_D_SEQ;
            end
            ST_D_SEQ: n_state = ST_D_HI;
            ST_D_HI:  n_state = ST_D_LO;
            ST_D_LO: begin
                if (w_len_remain != 16'd0) begin
                    n_state = ST_D_PAY;
                end else begin
                    n_state = (r_bytes >= r_size) ? ST_E_WAIT : ST_D_WAIT;
                end
            end
            ST_D_PAY: begin
                if (w_pay_remain == 16'd0) begin
                    n_state = (w_bytes_inc >= r_size) ? ST_E_WAIT : ST_D_WAIT;
                end
            end
            ST_E_WAIT: begin
                if (w_b == PKT_END) n_state = ST_E_TYPE;
            end
            ST_E_LEN: begin
                if (w_b != 8'd0) begin
                    n_state = ST_E_VAL;
                end else begin
                    n_state = w_fields_done ? ST_WAIT_START : ST_E_TYPE;
                end
            end
            ST_E_VAL: begin
                if (w_end_remain == 8'd0) begin
                    n_state = w_fields_done ? ST_WAIT_START : ST_E_TYPE;
                end
            end
            default: n_state = ST_WAIT_START;
        endcase
    end

    // Datapath, store access and the work handed to the second stage.
    always_comb begin
        n_fields = r_fields;
        n_remain = r_remain;
        n_ftype  = r_ftype;
        n_idx    = r_idx;
        n_size   = r_size;
        n_bytes  = r_bytes;
        n_seq    = r_seq;
        w_we     = 1'b0;
        w_re     = 1'b0;
        n_s1          = '0;
        n_s1.cmp_byte = w_b;

        unique case (r_state)
            ST_WAIT_START: begin
                if (w_b == PKT_START) begin
                    n_idx    = '0;
                    n_fields = 2'd0;
                    n_size   = 32'd0;
                end
            end
            ST_S_TYPE: begin
                if (w_tlv_type) begin
                    n_ftype = w_b[0];
                    if (w_b == TLV_SIZE) n_size = 32'd0;
                    if (w_idx_ok) begin
                        w_we  = 1'b1;
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_E_TYPE: begin
                if (w_tlv_type) begin
                    n_ftype = w_b[0];
                    if (w_idx_ok) begin
                        w_re       = 1'b1;
                        n_s1.cmp   = 1'b1;
                        n_s1.oob   = ({{(32 - CTRL_IDX_W){1'b0}}, r_idx} >= r_bytes);
                        n_idx      = r_idx + 1'b1;
                    end
                end
            end
            ST_S_LEN: begin
                if (w_idx_ok) begin
                    w_we  = 1'b1;
                    n_idx = r_idx + 1'b1;
                end
                n_remain = {8'd0, w_b};
                if (w_b == 8'd0) begin
                    n_fields = w_fields_inc;
                    if (w_fields_done) begin
                        n_bytes   = 32'd0;
                        n_s1.emit = 1'b1;
                        n_s1.kind = KIND_START;
                    end
                end
            end
            ST_S_VAL: begin
                if (w_idx_ok) begin
                    w_we  = 1'b1;
                    n_idx = r_idx + 1'b1;
                end
                if (!r_ftype) begin
                    // Only the first four value bytes form the little-endian size.
                    if (r_remain[15:10] == 6'd0) begin
                        case (r_remain[9:8])
                            2'd0:    n_size = r_size | {24'd0, w_b};
                            2'd1:    n_size = r_size | {16'd0, w_b, 8'd0};
                            2'd2:    n_size = r_size | {8'd0, w_b, 16'd0};
                            default: n_size = r_size | {w_b, 24'd0};
                        endcase
                    end
                end else begin
                    n_s1.emit = 1'b1;
                    n_s1.kind = KIND_NAME;
                    n_s1.data = w_b;
                end
                n_remain = w_val_remain;
                if (w_val_remain[7:0] == 8'd0) begin
                    n_fields = w_fields_inc;
                    if (w_fields_done) begin
                        n_bytes = 32'd0;
                        if (!r_ftype) begin
                            n_s1.emit = 1'b1;
                            n_s1.kind = KIND_START;
                        end
                    end
                end
            end
            ST_START_PEND: begin
                n_s1.emit = 1'b1;
                n_s1.kind = KIND_START;
            end
            ST_D_WAIT: begin
            end
            ST_D_SEQ: n_seq = w_b;
            ST_D_HI:  n_remain = {w_b, 8'd0};
            ST_D_LO:  n_remain = w_len_remain;
            ST_D_PAY: begin
                n_s1.emit = 1'b1;
                n_s1.kind = KIND_PAYLOAD;
                n_s1.data = w_b;
                n_s1.seq  = r_seq;
                n_s1.last = (r_remain == 16'd1);
                n_bytes   = w_bytes_inc;
                n_remain  = w_pay_remain;
            end
            ST_E_WAIT: begin
                if (w_b == PKT_END) begin
                    n_bytes     = {{(32 - CTRL_IDX_W){1'b0}}, r_idx};
                    n_idx       = '0;
                    n_fields    = 2'd0;
                    n_s1.clr_mm = 1'b1;
                end
            end
            ST_E_LEN, ST_E_VAL: begin
                if (w_idx_ok) begin
                    w_re     = 1'b1;
                    n_s1.cmp = 1'b1;
                    n_s1.oob = ({{(32 - CTRL_IDX_W){1'b0}}, r_idx} >= r_bytes);
                    n_idx    = r_idx + 1'b1;
                end
                if (r_state == ST_E_LEN) begin
                    n_remain = {8'd0, w_b};
                end else begin
                    n_remain = {8'd0, w_end_remain};
                end
                if ((r_state == ST_E_LEN && w_b == 8'd0) ||
                    (r_state == ST_E_VAL && w_end_remain == 8'd0)) begin
                    n_fields = w_fields_inc;
                    if (w_fields_done) begin
                        n_s1.emit     = 1'b1;
                        n_s1.verdict  = 1'b1;
                        n_s1.len_fail = ({{(32 - CTRL_IDX_W){1'b0}}, n_idx} != r_bytes);
                    end
                end
            end
            default: begin
            end
        endcase
        n_s1.size = n_size;
    end

    // Parse stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_WAIT_START;
            r_fields   <= 2'd0;
            r_remain   <= 16'd0;
            r_ftype    <= 1'b0;
            r_idx      <= '0;
            r_size     <= 32'd0;
            r_bytes    <= 32'd0;
            r_seq      <= 8'd0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state  <= n_state;
                r_fields <= n_fields;
                r_remain <= n_remain;
                r_ftype  <= n_ftype;
                r_idx    <= n_idx;
                r_size   <= n_size;
                r_bytes  <= n_bytes;
                r_seq    <= n_seq;
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
    end

    // Control field store. Reads only happen during the end packet and writes
    // only during the start packet, so an access never overlaps a write.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_we) begin
            r_ctrl_mem[r_idx[CTRL_ADDR_W-1:0]] <= w_b;
        end
        if (w_accept && w_re) begin
            r_rdata <= r_ctrl_mem[r_idx[CTRL_ADDR_W-1:0]];
        end
    end

    // Second stage: finish the comparison and settle the verdict.
    assign w_cmp_fail = r_s1.cmp && (r_s1.oob || (r_rdata != r_s1.cmp_byte));
    assign w_mm_eff   = (r_mismatch && !r_s1.clr_mm) || w_cmp_fail || r_s1.len_fail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mismatch <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_mismatch <= w_mm_eff;
            end
            if (w_s1_adv && r_s1.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1.emit) begin
            if (r_s1.verdict) begin
                r_o_kind <= w_mm_eff ? KIND_MISMATCH : KIND_MATCH;
            end else begin
                r_o_kind <= r_s1.kind;
            end
            r_o_data <= r_s1.data;
            r_o_seq  <= r_s1.seq;
            r_o_last <= r_s1.last;
            r_o_size <= r_s1.size;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_data_byte    = r_o_data;
    assign o_sequence_res = r_o_seq;
    assign o_packet_last  = r_o_last;
    assign o_decoded_size = r_o_size;

endmodule

// ----- bench/file_transfer_packet_deframer_tb.sv -----
// Self-checking testbench for the file transfer packet deframer, driven by a directed opening and random transfers.
module file_transfer_packet_deframer_tb
    import ftpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_ready   = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_sequence_res;
    logic        o_packet_last;
    logic [31:0] o_decoded_size;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [7:0]  seq;
        logic        last;
        logic [31:0] size;
    } t_deframed;

    // Follows the parser byte by byte and queues the results each request causes.
    class deframer_board;
        t_state      phase;
        logic [1:0]  fields_done;
        logic [15:0] remaining;
        logic        name_field;
        int unsigned ctrl_idx;
        logic [7:0]  ctrl_mem [CONTROL_BYTES];
        logic [31:0] size_sum;
        logic [31:0] payload_count;
        logic [7:0]  seq_now;
        logic        differs;
        t_deframed   awaited[$];
        int          errors;

        function new();
            phase         = ST_WAIT_START;
            fields_done   = '0;
            remaining     = '0;
            name_field    = 1'b0;
            ctrl_idx      = 0;
            size_sum      = '0;
            payload_count = '0;
            seq_now       = '0;
            differs       = 1'b0;
            errors        = 0;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void queue_result(logic [2:0] kind, logic [7:0] data, logic [7:0] seq,
                                   logic last);
            t_deframed r;
            r.kind = kind;
            r.data = data;
            r.seq  = seq;
            r.last = last;
            r.size = size_sum;
            awaited.push_back(r);
        endfunction

        function void keep_byte(logic [7:0] b);
            if (ctrl_idx < CONTROL_BYTES) begin
                ctrl_mem[ctrl_idx] = b;
                ctrl_idx++;
            end
        endfunction

        // Bytes past the stored count always differ; the store is never read there.
        function void compare_byte(logic [7:0] b);
            if (ctrl_idx < CONTROL_BYTES) begin
                if (ctrl_idx >= payload_count || ctrl_mem[ctrl_idx] != b)
                    differs = 1'b1;
                ctrl_idx++;
            end
        endfunction

        // When the last start field ends on a name byte, the start event waits one byte.
        function void start_field_closed(logic emitted);
            fields_done++;
            if (fields_done >= 2) begin
                payload_count = '0;
                if (emitted) begin
                    phase = ST_START_PEND;
                end else begin
                    phase = ST_D_WAIT;
                    queue_result(KIND_START, 8'h00, 8'h00, 1'b0);
                end
            end else begin
                phase = ST_S_TYPE;
            end
        endfunction

        function void end_field_closed();
            fields_done++;
            if (fields_done >= 2) begin
                if (ctrl_idx != payload_count)
                    differs = 1'b1;
                phase = ST_WAIT_START;
                queue_result(differs ? KIND_MISMATCH : KIND_MATCH, 8'h00, 8'h00, 1'b0);
            end else begin
                phase = ST_E_TYPE;
            end
        endfunction

        function void note_request(logic [7:0] b);
            logic [7:0] pos;
            case (phase)
                ST_WAIT_START: begin
                    if (b == PKT_START) begin
                        ctrl_idx    = 0;
                        fields_done = '0;
                        size_sum    = '0;
                        differs     = 1'b0;
                        phase       = ST_S_TYPE;
                    end
                end
                ST_S_TYPE: begin
                    if (b == TLV_SIZE || b == TLV_NAME) begin
                        name_field = (b == TLV_NAME);
                        if (b == TLV_SIZE)
                            size_sum = '0;
                        keep_byte(b);
                        phase = ST_S_LEN;
                    end
                end
                ST_E_TYPE: begin
                    if (b == TLV_SIZE || b == TLV_NAME) begin
                        name_field = (b == TLV_NAME);
                        compare_byte(b);
                        phase = ST_E_LEN;
                    end
                end
                ST_S_LEN: begin
                    keep_byte(b);
                    remaining = {8'h00, b};
                    if (b == 8'h00)
                        start_field_closed(1'b0);
                    else
                        phase = ST_S_VAL;
                end
                ST_S_VAL: begin
                    // The upper byte counts value bytes taken, the lower byte those left.
                    pos = remaining[15:8];
                    keep_byte(b);
                    if (!name_field) begin
                        if (pos < 4)
                            size_sum |= 32'(b) << (8 * pos);
                    end else begin
                        queue_result(KIND_NAME, b, 8'h00, 1'b0);
                    end
                    remaining = remaining + 16'h00FF;
                    if (remaining[7:0] == 8'h00)
                        start_field_closed(name_field);
                end
                ST_START_PEND: begin
                    queue_result(KIND_START, 8'h00, 8'h00, 1'b0);
                    phase = (b == PKT_DATA) ? ST_D_SEQ : ST_D_WAIT;
                end
                ST_D_WAIT: begin
                    if (b == PKT_DATA)
                        phase = ST_D_SEQ;
                end
                ST_D_SEQ: begin
                    seq_now = b;
                    phase   = ST_D_HI;
                end
                ST_D_HI: begin
                    remaining = {b, 8'h00};
                    phase     = ST_D_LO;
                end
                ST_D_LO: begin
                    remaining[7:0] = b;
                    if (remaining == 16'h0000)
                        phase = (payload_count >= size_sum) ? ST_E_WAIT : ST_D_WAIT;
                    else
                        phase = ST_D_PAY;
                end
                ST_D_PAY: begin
                    queue_result(KIND_PAYLOAD, b, seq_now, remaining == 16'h0001);
                    if (payload_count != 32'hFFFF_FFFF)
                        payload_count++;
                    remaining--;
                    if (remaining == 16'h0000)
                        phase = (payload_count >= size_sum) ? ST_E_WAIT : ST_D_WAIT;
                end
                ST_E_WAIT: begin
                    // From here payload_count holds the number of stored start bytes.
                    if (b == PKT_END) begin
                        payload_count = ctrl_idx;
                        ctrl_idx      = 0;
                        fields_done   = '0;
                        differs       = 1'b0;
                        phase         = ST_E_TYPE;
                    end
                end
                ST_E_LEN: begin
                    compare_byte(b);
                    remaining = {8'h00, b};
                    if (b == 8'h00)
                        end_field_closed();
                    else
                        phase = ST_E_VAL;
                end
                ST_E_VAL: begin
                    compare_byte(b);
                    remaining = {8'h00, remaining[7:0] - 8'd1};
                    if (remaining == 16'h0000)
                        end_field_closed();
                end
                default: begin
                    phase = ST_WAIT_START;
                end
            endcase
        endfunction

        function void check_result(logic [2:0] kind, logic [7:0] data, logic [7:0] seq,
                                   logic last, logic [31:0] size);
            t_deframed want;
            if (awaited.size() == 0) begin
                $error("unexpected result: kind %0d data 0x%02h", kind, data);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (data !== want.data) begin
                $error("data_byte: expected 0x%02h, got 0x%02h", want.data, data);
                errors++;
            end
            if (seq !== want.seq) begin
                $error("sequence_res: expected 0x%02h, got 0x%02h", want.seq, seq);
                errors++;
            end
            if (last !== want.last) begin
                $error("packet_last: expected %0b, got %0b", want.last, last);
                errors++;
            end
            if (size !== want.size) begin
                $error("decoded_size: expected %0d, got %0d", want.size, size);
                errors++;
            end
        endfunction
    endclass

    deframer_board board;
    int unsigned   sent_count = 0;
    bit            send_calm  = 1'b0;
    bit            recv_calm  = 1'b0;

    file_transfer_packet_deframer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_sequence_res (o_sequence_res),
        .o_packet_last  (o_packet_last),
        .o_decoded_size (o_decoded_size)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_gap(bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 16);
    endfunction

    function automatic logic [7:0] stray(logic [7:0] avoid);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (v == avoid)
            v = ~v;
        return v;
    endfunction

    // One control field, sometimes behind unknown type bytes. A size field carries
    // file_len little-endian; bytes past the fourth are random and must be ignored.
    function automatic void add_field(ref logic [7:0] q[$], input bit is_name,
                                      input int unsigned file_len);
        int unsigned len;
        int unsigned low;
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) q.push_back(8'($urandom_range(2, 255)));
        if (is_name) begin
            len = ($urandom_range(0, 49) == 0) ? $urandom_range(128, 255)
                                               : $urandom_range(0, 8);
            q.push_back(TLV_NAME);
            q.push_back(8'(len));
            repeat (len) q.push_back(8'($urandom));
        end else begin
            low = (file_len == 0) ? 0 : (file_len < 256) ? 1 : 2;
            len = $urandom_range(low, 6);
            q.push_back(TLV_SIZE);
            q.push_back(8'(len));
            for (int i = 0; i < len; i++)
                q.push_back(i < 2 ? 8'(file_len >> (8 * i)) : i < 4 ? 8'h00 : 8'($urandom));
        end
    endfunction

    function automatic void build_transfer(ref logic [7:0] q[$]);
        logic [7:0]  fields[$];
        int unsigned file_len;
        int unsigned sent;
        int unsigned len;
        int unsigned layout;
        int unsigned flip;
        bit          name_first;
        file_len   = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300)
                                                  : $urandom_range(0, 24);
        layout     = $urandom_range(0, 9);
        name_first = $urandom_range(0, 1);
        if (layout == 0) begin
            // Two name fields: the size stays zero.
            file_len = 0;
            add_field(fields, 1'b1, 0);
            add_field(fields, 1'b1, 0);
        end else if (layout == 1) begin
            // Two size fields: only the later one counts.
            add_field(fields, 1'b0, $urandom_range(0, 300));
            add_field(fields, 1'b0, file_len);
        end else begin
            add_field(fields, name_first, file_len);
            add_field(fields, !name_first, file_len);
        end

        repeat ($urandom_range(0, 2)) q.push_back(stray(PKT_START));
        q.push_back(PKT_START);
        foreach (fields[i]) q.push_back(fields[i]);

        sent = 0;
        do begin
            if ($urandom_range(0, 4) == 0)
                q.push_back(stray(PKT_DATA));
            q.push_back(PKT_DATA);
            q.push_back(8'($urandom));
            len = ($urandom_range(0, 39) == 0) ? 256 + $urandom_range(0, 8)
                                               : $urandom_range(0, 12);
            q.push_back(8'(len >> 8));
            q.push_back(8'(len));
            repeat (len) q.push_back(8'($urandom));
            sent += len;
        end while (sent < file_len);

        if ($urandom_range(0, 2) == 0)
            q.push_back(stray(PKT_END));
        q.push_back(PKT_END);
        flip = $urandom_range(0, 19);
        if (flip < 3) begin
            fields.delete();
            add_field(fields, name_first, $urandom_range(0, 24));
            add_field(fields, !name_first, $urandom_range(0, 24));
        end else if (flip < 6) begin
            flip = $urandom_range(0, fields.size() - 1);
            fields[flip] = fields[flip] ^ 8'($urandom_range(1, 255));
        end
        foreach (fields[i]) q.push_back(fields[i]);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(b);
        sent_count++;
    endtask

    // Always waits on the clock before checking, so the next request starts in a later time step.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
    endtask

    // A transfer, sometimes cut short and followed by noise, or one to six random
    // bytes; then bytes that walk the parser back to waiting for a start packet.
    task automatic run_transfer();
        logic [7:0]  q[$];
        logic [7:0]  b;
        int unsigned cut;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
            cut = q.size();
        end else begin
            build_transfer(q);
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, q.size() - 1) : q.size();
        end
        for (int i = 0; i < cut; i++)
            send_byte(q[i]);
        if (cut != q.size()) begin
            // Noise must not set a huge length or size, or the walk back takes forever.
            repeat ($urandom_range(1, 4)) begin
                if (board.phase == ST_D_HI)
                    b = 8'($urandom_range(0, 1));
                else if (board.phase == ST_S_VAL)
                    b = 8'h00;
                else
                    b = 8'($urandom);
                send_byte(b);
            end
        end
        while (board.phase != ST_WAIT_START) begin
            case (board.phase)
                ST_START_PEND, ST_D_WAIT:  b = PKT_DATA;
                ST_D_LO:                   b = 8'($urandom_range(1, 20));
                ST_D_SEQ, ST_D_PAY, ST_E_VAL: b = 8'($urandom);
                ST_E_WAIT:                 b = PKT_END;
                default:                   b = 8'h00;
            endcase
            send_byte(b);
        end
    endtask

    initial begin
        logic [7:0]  opening[$];
        int unsigned drain;
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Stray byte, unknown type, a name that closes the start packet, a zero-length
        // packet, payload bytes 0x00 and 0xFF, and an end packet that matches.
        opening = '{8'hFF, PKT_START, 8'h07, TLV_SIZE, 8'h01, 8'h02, TLV_NAME, 8'h01,
                    8'h80, PKT_DATA, 8'h07, 8'h00, 8'h00, PKT_DATA, 8'hFF, 8'h00, 8'h02,
                    8'h00, 8'hFF, 8'h55, PKT_END, TLV_SIZE, 8'h01, 8'h02, TLV_NAME,
                    8'h01, 8'h80};
        foreach (opening[i]) send_byte(opening[i]);
        wait_drained();

        while (sent_count < 900) begin
            send_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                wait_drained();
            run_transfer();
        end

        i_valid <= 1'b0;
        drain = 0;
        while (board.outstanding() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);
        if (board.outstanding() != 0) begin
            $error("%0d expected results never arrived", board.outstanding());
            board.errors++;
        end
        if (board.errors == 0)
            $display("file_transfer_packet_deframer: match");
        else
            $display("file_transfer_packet_deframer: mismatch");
        $finish;
    end

    initial begin
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0)
                recv_calm = !recv_calm;
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            board.check_result(o_kind, o_data_byte, o_sequence_res, o_packet_last,
                               o_decoded_size);
        end
    end

    initial begin
        #2ms;
        $display("file_transfer_packet_deframer: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/ftpd_pkg.sv
hw/rtl/file_transfer_packet_deframer.sv
bench/file_transfer_packet_deframer_tb.sv
